// ===== design/ansi_text_terminal_assert.svh =====
// ansi_text_terminal_assert.svh: assertion macros for the terminal checkers
// depends on nothing; expects i_clk and i_rst_n in the scope that uses it
`ifndef ANSI_TEXT_TERMINAL_ASSERT_SVH
`define ANSI_TEXT_TERMINAL_ASSERT_SVH

// implication checked on every clock edge out of reset
`define ATT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define ATT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/att_pkg.sv =====
`timescale 1ns / 1ps
// att_pkg: shared types, constants and helpers of the text terminal
// no dependencies

package att_pkg;

    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int MAX_PARAMS_DEF = 8;
    localparam int FQ_DEPTH       = 2;

    localparam logic [7:0]  CH_ESC    = 8'h1B;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  ATTR_DEF  = 8'h07;
    localparam logic [15:0] CELL_DEF  = 16'h0720;

    typedef enum logic [4:0] {
        K_OTHER, K_DIGIT, K_SEMI, K_LBRK, K_ESC, K_NL, K_CR, K_BS,
        K_SGR, K_ED, K_CUU, K_CUD, K_CUF, K_CUB, K_CUP, K_EL, K_SCP, K_RCP
    } t_kind;

    typedef struct packed {
        logic        rd;
        logic [7:0]  ch;
        logic [10:0] idx;
        t_kind       kind;
    } t_item;

    // ansi color code order to vga color order
    function automatic logic [2:0] fg_code(input logic [2:0] c);
        logic [2:0] r;
        case (c)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd6;
            3'd4:    r = 3'd1;
            3'd5:    r = 3'd5;
            3'd6:    r = 3'd3;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

// ===== design/att_front.sv =====
`timescale 1ns / 1ps
// att_front: input word queue that tags each byte with its kind
// depends on att_pkg

module att_front import att_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_command,
    input  logic [7:0]  i_char_byte,
    input  logic [10:0] i_cell_index,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_take
);
    localparam int FQW = $clog2(FQ_DEPTH);
    localparam int FCW = $clog2(FQ_DEPTH + 1);

    t_item           r_q [FQ_DEPTH];
    logic [FQW-1:0]  r_wp, r_rp;
    logic [FCW-1:0]  r_cnt;
    logic            w_push, w_pop;
    t_kind           w_kind;

    always_comb begin
        unique case (i_char_byte)
            "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": w_kind = K_DIGIT;
            ";":     w_kind = K_SEMI;
            "[":     w_kind = K_LBRK;
            CH_ESC:  w_kind = K_ESC;
            8'h0A:   w_kind = K_NL;
            8'h0D:   w_kind = K_CR;
            8'h08:   w_kind = K_BS;
            "m":     w_kind = K_SGR;
            "J":     w_kind = K_ED;
            "A":     w_kind = K_CUU;
            "B":     w_kind = K_CUD;
            "C":     w_kind = K_CUF;
            "D":     w_kind = K_CUB;
            "H", "f": w_kind = K_CUP;
            "K":     w_kind = K_EL;
            "s":     w_kind = K_SCP;
            "u":     w_kind = K_RCP;
            default: w_kind = K_OTHER;
        endcase
    end

    assign o_full  = (r_cnt == FCW'(FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{rd: i_command, ch: i_char_byte, idx: i_cell_index, kind: w_kind};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == FQW'(FQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == FQW'(FQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (w_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== design/att_back.sv =====
`timescale 1ns / 1ps
// att_back: escape parser, cursor logic, screen memory sequencer and result register
// depends on att_pkg

module att_back import att_pkg::*; #(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_take,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic [7:0]  o_attribute,
    output logic [10:0] o_hw_cursor_pos,
    output logic [15:0] o_cell_data
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = $clog2(MAX_PARAMS);
    localparam int NW    = $clog2(MAX_PARAMS + 1);

    typedef enum logic [3:0] {
        S_FILL, S_IDLE, S_RDW, S_SGR, S_PUTC, S_SCR_RD, S_SCR_WR, S_HW, S_POST
    } t_state;
    typedef enum logic [1:0] { A_IDLE, A_HW, A_POST } t_after;
    typedef enum logic [1:0] { M_NORM, M_ESC, M_PAR } t_mode;

    t_state          r_state;
    t_after          r_after;
    t_mode           r_mode;
    logic [15:0]     r_mem [CELLS];
    logic [15:0]     r_rdata;
    logic [AW-1:0]   r_addr, r_end;
    logic [15:0]     r_fill_data;
    logic [RW-1:0]   r_row, r_srow;
    logic [CW-1:0]   r_col, r_scol;
    logic [7:0]      r_attr;
    logic [7:0]      r_param [MAX_PARAMS];
    logic [NW-1:0]   r_cnt, r_sgr_i;
    logic [3:0]      r_fg, r_bg;
    logic            r_bright;
    logic [10:0]     r_hw;
    logic [15:0]     r_cell;
    logic [7:0]      r_ch;
    logic            r_adv;
    logic            r_out_valid;
    logic [4:0]      r_o_row;
    logic [6:0]      r_o_col;
    logic [7:0]      r_o_attr;
    logic [10:0]     r_o_hw;
    logic [15:0]     r_o_cell;

    logic [AW-1:0]   w_base, w_pos, w_raddr, w_waddr;
    logic [15:0]     w_wdata;
    logic            w_we;
    logic [7:0]      w_p0, w_p1, w_n, w_p, w_digit;
    logic [8:0]      w_row9, w_col9, w_n9;
    logic [NW-1:0]   w_cnt_inc;

    assign w_base    = AW'(r_row) * AW'(COLUMNS);
    assign w_pos     = w_base + AW'(r_col);
    assign w_p0      = r_param[0];
    assign w_p1      = r_param[1];
    assign w_n       = (w_p0 != 8'd0) ? w_p0 : 8'd1;
    assign w_row9    = 9'(r_row);
    assign w_col9    = 9'(r_col);
    assign w_n9      = 9'(w_n);
    assign w_cnt_inc = (r_cnt < NW'(MAX_PARAMS)) ? r_cnt + 1'b1 : r_cnt;
    assign w_p       = r_param[r_sgr_i[PW-1:0]];
    assign w_digit   = i_item.ch - CH_ZERO;
    assign o_take    = (r_state == S_IDLE);

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_fill_data;
        w_raddr = AW'(i_item.idx);
        case (r_state)
            S_FILL: w_we = 1'b1;
            S_PUTC: begin
                w_we    = 1'b1;
                w_waddr = w_pos;
                w_wdata = {r_attr, r_ch};
            end
            S_SCR_RD: w_raddr = r_addr + AW'(COLUMNS);
            S_SCR_WR: begin
                w_we    = 1'b1;
                w_wdata = r_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_after     <= A_IDLE;
            r_mode      <= M_NORM;
            r_addr      <= '0;
            r_end       <= AW'(CELLS - 1);
            r_fill_data <= CELL_DEF;
            r_row       <= '0;
            r_col       <= '0;
            r_srow      <= '0;
            r_scol      <= '0;
            r_attr      <= ATTR_DEF;
            r_cnt       <= '0;
            r_sgr_i     <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_PARAMS; i++) r_param[i] <= 8'd0;
        end else begin
            if (r_out_valid && i_pop && r_state != S_POST) r_out_valid <= 1'b0;
            unique case (r_state)
                S_FILL: begin
                    if (r_addr == r_end) begin
                        unique case (r_after)
                            A_HW:    r_state <= S_HW;
                            A_POST:  r_state <= S_POST;
                            default: r_state <= S_IDLE;
                        endcase
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cell <= 16'd0;
                        if (i_item.rd) begin
                            r_state <= (32'(i_item.idx) < CELLS) ? S_RDW : S_POST;
                        end else begin
                            unique case (r_mode)
                                M_ESC: begin
                                    r_state <= S_POST;
                                    if (i_item.kind == K_LBRK) begin
                                        r_mode <= M_PAR;
                                        r_cnt  <= '0;
                                        for (int i = 0; i < MAX_PARAMS; i++) r_param[i] <= 8'd0;
                                    end else begin
                                        r_mode <= M_NORM;
                                    end
                                end
                                M_PAR: begin
                                    case (i_item.kind)
                                        K_DIGIT: begin
                                            r_state <= S_POST;
                                            if (r_cnt < NW'(MAX_PARAMS))
                                                r_param[r_cnt[PW-1:0]] <=
                                                    (r_param[r_cnt[PW-1:0]] << 3) +
                                                    (r_param[r_cnt[PW-1:0]] << 1) + w_digit;
                                        end
                                        K_SEMI: begin
                                            r_state <= S_POST;
                                            if (r_cnt < NW'(MAX_PARAMS - 1)) r_cnt <= r_cnt + 1'b1;
                                        end
                                        default: begin
                                            r_mode <= M_NORM;
                                            r_cnt  <= w_cnt_inc;
                                            case (i_item.kind)
                                                K_SGR: begin
                                                    r_sgr_i  <= '0;
                                                    r_fg     <= r_attr[3:0];
                                                    r_bg     <= r_attr[7:4];
                                                    r_bright <= 1'b0;
                                                    r_state  <= S_SGR;
                                                end
                                                K_ED: begin
                                                    if (w_p0 == 8'd2) begin
                                                        r_addr      <= '0;
                                                        r_end       <= AW'(CELLS - 1);
                                                        r_fill_data <= {r_attr, CH_SPACE};
                                                        r_after     <= A_HW;
                                                        r_row       <= '0;
                                                        r_col       <= '0;
                                                        r_state     <= S_FILL;
                                                    end else begin
                                                        r_state     <= S_POST;
                                                    end
                                                end
                                                K_CUU: begin
                                                    r_row <= (w_row9 >= w_n9) ?
                                                        RW'(w_row9 - w_n9) : '0;
                                                    r_state <= S_HW;
                                                end
                                                K_CUD: begin
                                                    r_row <= (w_row9 + w_n9 < 9'(ROWS)) ?
                                                        RW'(w_row9 + w_n9) : RW'(ROWS - 1);
                                                    r_state <= S_HW;
                                                end
                                                K_CUF: begin
                                                    r_col <= (w_col9 + w_n9 < 9'(COLUMNS)) ?
                                                        CW'(w_col9 + w_n9) : CW'(COLUMNS - 1);
                                                    r_state <= S_HW;
                                                end
                                                K_CUB: begin
                                                    r_col <= (w_col9 >= w_n9) ?
                                                        CW'(w_col9 - w_n9) : '0;
                                                    r_state <= S_HW;
                                                end
                                                K_CUP: begin
                                                    if (w_p0 == 8'd0) r_row <= '0;
                                                    else if (9'(w_p0) - 9'd1 >= 9'(ROWS))
                                                        r_row <= RW'(ROWS - 1);
                                                    else r_row <= RW'(w_p0 - 8'd1);
                                                    if (w_p1 == 8'd0) r_col <= '0;
                                                    else if (9'(w_p1) - 9'd1 >= 9'(COLUMNS))
                                                        r_col <= CW'(COLUMNS - 1);
                                                    else r_col <= CW'(w_p1 - 8'd1);
                                                    r_state <= S_POST;
                                                end
                                                K_EL: begin
                                                    r_fill_data <= {r_attr, CH_SPACE};
                                                    r_after     <= A_POST;
                                                    if (w_p0 == 8'd0) begin
                                                        r_addr  <= w_pos;
                                                        r_end   <= w_base + AW'(COLUMNS - 1);
                                                        r_state <= S_FILL;
                                                    end else if (w_p0 == 8'd1) begin
                                                        r_addr  <= w_base;
                                                        r_end   <= w_pos;
                                                        r_state <= S_FILL;
                                                    end else if (w_p0 == 8'd2) begin
                                                        r_addr  <= w_base;
                                                        r_end   <= w_base + AW'(COLUMNS - 1);
                                                        r_state <= S_FILL;
                                                    end else begin
                                                        r_state <= S_POST;
                                                    end
                                                end
                                                K_SCP: begin
                                                    r_srow  <= r_row;
                                                    r_scol  <= r_col;
                                                    r_state <= S_HW;
                                                end
                                                K_RCP: begin
                                                    r_row   <= r_srow;
                                                    r_col   <= r_scol;
                                                    r_state <= S_HW;
                                                end
                                                default: r_state <= S_POST;
                                            endcase
                                        end
                                    endcase
                                end
                                default: begin
                                    case (i_item.kind)
                                        K_ESC: begin
                                            r_mode  <= M_ESC;
                                            r_state <= S_POST;
                                        end
                                        K_NL: begin
                                            r_col <= '0;
                                            if (w_row9 + 9'd1 >= 9'(ROWS)) begin
                                                r_row   <= RW'(ROWS - 1);
                                                r_addr  <= '0;
                                                r_state <= S_SCR_RD;
                                            end else begin
                                                r_row   <= r_row + 1'b1;
                                                r_state <= S_HW;
                                            end
                                        end
                                        K_CR: begin
                                            r_col   <= '0;
                                            r_state <= S_HW;
                                        end
                                        K_BS: begin
                                            if (r_col != '0) begin
                                                r_col <= r_col - 1'b1;
                                            end else if (r_row != '0) begin
                                                r_row <= r_row - 1'b1;
                                                r_col <= CW'(COLUMNS - 1);
                                            end
                                            r_ch    <= CH_SPACE;
                                            r_adv   <= 1'b0;
                                            r_state <= S_PUTC;
                                        end
                                        default: begin
                                            r_ch    <= i_item.ch;
                                            r_adv   <= 1'b1;
                                            r_state <= S_PUTC;
                                        end
                                    endcase
                                end
                            endcase
                        end
                    end
                end
                S_RDW: begin
                    r_cell  <= r_rdata;
                    r_state <= S_POST;
                end
                S_SGR: begin
                    if (r_sgr_i == r_cnt) begin
                        r_attr  <= {r_bg, (r_bright && !r_fg[3]) ? {1'b1, r_fg[2:0]} : r_fg};
                        r_state <= S_POST;
                    end else begin
                        r_sgr_i <= r_sgr_i + 1'b1;
                        if (w_p == 8'd0) begin
                            r_fg     <= 4'd7;
                            r_bg     <= 4'd0;
                            r_bright <= 1'b0;
                        end else if (w_p == 8'd1) begin
                            r_bright <= 1'b1;
                        end else if (w_p >= 8'd30 && w_p <= 8'd37) begin
                            r_fg <= {1'b0, fg_code(3'(w_p - 8'd30))};
                        end else if (w_p >= 8'd90 && w_p <= 8'd97) begin
                            r_fg <= {1'b1, fg_code(3'(w_p - 8'd90))};
                        end else if (w_p >= 8'd40 && w_p <= 8'd47) begin
                            r_bg <= {1'b0, fg_code(3'(w_p - 8'd40))};
                        end else if (w_p >= 8'd100 && w_p <= 8'd107) begin
                            r_bg <= {1'b1, fg_code(3'(w_p - 8'd100))};
                        end
                    end
                end
                S_PUTC: begin
                    if (r_adv && (w_col9 + 9'd1 >= 9'(COLUMNS))) begin
                        r_col <= '0;
                        if (w_row9 + 9'd1 >= 9'(ROWS)) begin
                            r_row   <= RW'(ROWS - 1);
                            r_addr  <= '0;
                            r_state <= S_SCR_RD;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_state <= S_HW;
                        end
                    end else begin
                        if (r_adv) r_col <= r_col + 1'b1;
                        r_state <= S_HW;
                    end
                end
                S_SCR_RD: r_state <= S_SCR_WR;
                S_SCR_WR: begin
                    if (r_addr == AW'(CELLS - COLUMNS - 1)) begin
                        r_addr      <= AW'(CELLS - COLUMNS);
                        r_end       <= AW'(CELLS - 1);
                        r_fill_data <= {r_attr, CH_SPACE};
                        r_after     <= A_HW;
                        r_state     <= S_FILL;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_SCR_RD;
                    end
                end
                S_HW: begin
                    r_hw    <= 11'(w_pos);
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (!r_out_valid || i_pop) begin
                        r_out_valid <= 1'b1;
                        r_o_row     <= 5'(r_row);
                        r_o_col     <= 7'(r_col);
                        r_o_attr    <= r_attr;
                        r_o_hw      <= r_hw;
                        r_o_cell    <= r_cell;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_cursor_row    = r_o_row;
    assign o_cursor_col    = r_o_col;
    assign o_attribute     = r_o_attr;
    assign o_hw_cursor_pos = r_o_hw;
    assign o_cell_data     = r_o_cell;

endmodule

// ===== design/ansi_text_terminal.sv =====
`timescale 1ns / 1ps
// ansi_text_terminal: top level of the text console engine
// depends on att_pkg, att_front, att_back
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------
//  input    | i_command i_char_byte i_cell_index      | i_push / o_full
//  result   | o_cursor_row o_cursor_col o_attribute   | o_empty / i_pop
//           | o_hw_cursor_pos o_cell_data             |
//
// a word goes from S_IDLE to S_POST (escape bytes, parameters, cursor set) or through
// S_PUTC and S_HW (printable byte, backspace); a read goes through S_RDW, as the screen
// memory has a registered read port; scroll copies each cell of the lower rows up by
// alternating S_SCR_RD and S_SCR_WR, then fills the last row; clear screen fills
// ROWS*COLUMNS cells and erase in line up to COLUMNS cells; sgr takes one parameter per
// S_SGR step; after reset a clearing pass over all ROWS*COLUMNS cells blanks the screen;
// the back end takes no word until it is done
// the input queue takes up to FQ_DEPTH words while the back end works or waits on i_pop

module ansi_text_terminal import att_pkg::*; #(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_command,
    input  logic [7:0]  i_char_byte,
    input  logic [10:0] i_cell_index,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic [7:0]  o_attribute,
    output logic [10:0] o_hw_cursor_pos,
    output logic [15:0] o_cell_data
);
    // words between front and back
    logic  w_valid;
    logic  w_take;
    t_item w_item;

    // front: queue and byte classification
    att_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_command    (i_command),
        .i_char_byte  (i_char_byte),
        .i_cell_index (i_cell_index),
        .o_valid      (w_valid),
        .o_item       (w_item),
        .i_take       (w_take)
    );

    // back: parser, cursor, screen memory and result register
    att_back #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_valid),
        .i_item          (w_item),
        .o_take          (w_take),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_col    (o_cursor_col),
        .o_attribute     (o_attribute),
        .o_hw_cursor_pos (o_hw_cursor_pos),
        .o_cell_data     (o_cell_data)
    );

endmodule

// ===== design/att_checker.sv =====
`timescale 1ns / 1ps
// att_checker: port level checks of the text terminal, bound to the top level
// depends on ansi_text_terminal_assert.svh and ansi_text_terminal

`include "ansi_text_terminal_assert.svh"

module att_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pop,
    input logic        o_empty,
    input logic [4:0]  o_cursor_row,
    input logic [6:0]  o_cursor_col,
    input logic [15:0] o_cell_data
);
    `ATT_ASSERT_IMP(a_empty_after_reset, $past(!i_rst_n), o_empty, "result shown after reset")
    `ATT_ASSERT_NEXT(a_hold, !o_empty && !i_pop, !o_empty && $stable(o_cell_data), "result lost")
    `ATT_ASSERT_IMP(a_col_range, !o_empty, int'(o_cursor_col) < COLUMNS, "column out of range")
    `ATT_ASSERT_IMP(a_row_range, !o_empty, int'(o_cursor_row) < ROWS, "row out of range")
endmodule

bind ansi_text_terminal att_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_att_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_pop        (i_pop),
    .o_empty      (o_empty),
    .o_cursor_row (o_cursor_row),
    .o_cursor_col (o_cursor_col),
    .o_cell_data  (o_cell_data)
);

// ===== test/ansi_text_terminal_tb.sv =====
`timescale 1ns / 1ps
// ansi_text_terminal_tb: self-checking bench for the text console engine
// depends on att_pkg and ansi_text_terminal; a shadow console predicts every status word

module ansi_text_terminal_tb;
    import att_pkg::*;

    localparam int NCOL  = 80;
    localparam int NROW  = 25;
    localparam int NPAR  = 8;
    localparam int NCELL = NCOL * NROW;
    localparam int CYCLE_LIMIT = 50000000;

    // shadow parser states
    typedef enum logic [1:0] { PS_TEXT, PS_ESC, PS_CSI } t_parse;

    // one status word as the block reports it
    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [7:0]  attr;
        logic [10:0] hw;
        logic [15:0] cdata;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        i_command = 1'b0;
    logic [7:0]  i_char_byte = 8'd0;
    logic [10:0] i_cell_index = 11'd0;
    logic        i_pop = 1'b0;
    logic        o_full, o_empty;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic [7:0]  o_attribute;
    logic [10:0] o_hw_cursor_pos;
    logic [15:0] o_cell_data;

    ansi_text_terminal u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full),
        .i_command(i_command), .i_char_byte(i_char_byte), .i_cell_index(i_cell_index),
        .o_empty(o_empty), .i_pop(i_pop),
        .o_cursor_row(o_cursor_row), .o_cursor_col(o_cursor_col),
        .o_attribute(o_attribute), .o_hw_cursor_pos(o_hw_cursor_pos),
        .o_cell_data(o_cell_data)
    );

    always #6 i_clk = ~i_clk;

    // shadow console state
    logic [15:0] screen [NCELL];
    int          cur_row, cur_col, save_row, save_col;
    logic [7:0]  cur_attr;
    t_parse      pmode;
    logic [7:0]  pars [NPAR];
    int          par_cnt;
    logic [10:0] hw_pos;

    t_status pending_status [$];
    int      errors = 0;
    int      words_sent = 0;
    int      words_checked = 0;
    int      cycles = 0;
    bit      hold_req = 1'b0;

    function automatic logic [3:0] vga_color(input int code);
        logic [3:0] map [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};
        return map[code];
    endfunction

    task automatic put_cell(input int x, input int y, input logic [7:0] ch);
        if (x < NCOL && y < NROW) screen[y*NCOL + x] = {cur_attr, ch};
    endtask

    task automatic update_hw();
        hw_pos = 11'((cur_row * NCOL + cur_col) & 11'h7FF);
    endtask

    task automatic scroll_screen();
        for (int x = 0; x < NCELL - NCOL; x++) screen[x] = screen[x + NCOL];
        for (int x = 0; x < NCOL; x++) put_cell(x, NROW - 1, CH_SPACE);
        cur_row = NROW - 1;
    endtask

    task automatic apply_colors();
        int fg, bg, p;
        bit bright;
        fg = cur_attr[3:0];
        bg = cur_attr[7:4];
        bright = 1'b0;
        for (int i = 0; i < par_cnt && i < NPAR; i++) begin
            p = pars[i];
            if (p == 0) begin
                fg = 7; bg = 0; bright = 1'b0;
            end else if (p == 1) bright = 1'b1;
            else if (p >= 30 && p <= 37) fg = vga_color(p - 30);
            else if (p >= 90 && p <= 97) fg = vga_color(p - 90) + 8;
            else if (p >= 40 && p <= 47) bg = vga_color(p - 40);
            else if (p >= 100 && p <= 107) bg = vga_color(p - 100) + 8;
        end
        if (bright && fg < 8) fg += 8;
        cur_attr = {4'(bg), 4'(fg)};
    endtask

    task automatic run_final(input logic [7:0] c);
        int p0, p1, n;
        p0 = pars[0];
        p1 = pars[1];
        n = (p0 != 0) ? p0 : 1;
        if (par_cnt < NPAR) par_cnt++;
        case (c)
            "m": apply_colors();
            "J": if (p0 == 2) begin
                for (int x = 0; x < NCELL; x++) screen[x] = {cur_attr, CH_SPACE};
                cur_row = 0; cur_col = 0; update_hw();
            end
            "A": begin cur_row = (cur_row >= n) ? cur_row - n : 0; update_hw(); end
            "B": begin cur_row = (cur_row + n < NROW) ? cur_row + n : NROW - 1; update_hw(); end
            "C": begin cur_col = (cur_col + n < NCOL) ? cur_col + n : NCOL - 1; update_hw(); end
            "D": begin cur_col = (cur_col >= n) ? cur_col - n : 0; update_hw(); end
            "H", "f": begin
                cur_row = (p0 != 0) ? p0 - 1 : 0;
                cur_col = (p1 != 0) ? p1 - 1 : 0;
                if (cur_row >= NROW) cur_row = NROW - 1;
                if (cur_col >= NCOL) cur_col = NCOL - 1;
            end
            "K": begin
                if (p0 == 0) for (int x = cur_col; x < NCOL; x++) put_cell(x, cur_row, CH_SPACE);
                else if (p0 == 1) for (int x = 0; x <= cur_col; x++) put_cell(x, cur_row, CH_SPACE);
                else if (p0 == 2) for (int x = 0; x < NCOL; x++) put_cell(x, cur_row, CH_SPACE);
            end
            "s": begin save_row = cur_row; save_col = cur_col; update_hw(); end
            "u": begin cur_row = save_row; cur_col = save_col; update_hw(); end
            default: ;
        endcase
        pmode = PS_TEXT;
    endtask

    task automatic console_feed(input logic [7:0] c);
        if (pmode == PS_ESC) begin
            if (c == "[") begin
                pmode = PS_CSI;
                par_cnt = 0;
                for (int i = 0; i < NPAR; i++) pars[i] = 8'd0;
            end else pmode = PS_TEXT;
        end else if (pmode == PS_CSI) begin
            if (c >= "0" && c <= "9") begin
                if (par_cnt < NPAR) pars[par_cnt] = 8'(pars[par_cnt] * 10 + (c - CH_ZERO));
            end else if (c == ";") begin
                if (par_cnt < NPAR - 1) par_cnt++;
            end else run_final(c);
        end else if (c == CH_ESC) begin
            pmode = PS_ESC;
        end else begin
            if (c == 8'h0A) begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= NROW) scroll_screen();
            end else if (c == 8'h0D) begin
                cur_col = 0;
            end else if (c == 8'h08) begin
                if (cur_col > 0) cur_col--;
                else if (cur_row > 0) begin
                    cur_row--; cur_col = NCOL - 1;
                end
                put_cell(cur_col, cur_row, CH_SPACE);
            end else begin
                put_cell(cur_col, cur_row, c);
                cur_col++;
                if (cur_col >= NCOL) begin
                    cur_col = 0;
                    cur_row++;
                    if (cur_row >= NROW) scroll_screen();
                end
            end
            update_hw();
        end
    endtask

    // advance the shadow console by one word and queue the status it yields
    task automatic predict_status(input logic rd, input logic [7:0] ch, input logic [10:0] idx);
        t_status s;
        s.cdata = 16'd0;
        if (rd) begin
            if (idx < NCELL) s.cdata = screen[idx];
        end else console_feed(ch);
        s.row  = 5'(cur_row);
        s.col  = 7'(cur_col);
        s.attr = cur_attr;
        s.hw   = hw_pos;
        pending_status.push_back(s);
    endtask

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one word and hold it until the queue takes it
    task automatic send_word(input logic rd, input logic [7:0] ch, input logic [10:0] idx);
        int gap;
        i_command    <= rd;
        i_char_byte  <= ch;
        i_cell_index <= idx;
        i_push       <= 1'b1;
        do @(posedge i_clk); while (o_full);
        predict_status(rd, ch, idx);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i], 11'($urandom));
    endtask

    task automatic read_cell(input int idx);
        send_word(1'b1, 8'($urandom), 11'(idx));
    endtask

    // result side: random pop with stalls, compare each word taken
    initial begin : status_checker
        t_status want;
        int stall;
        int r;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                if (pending_status.size() == 0) begin
                    $display("%0t: unexpected status word row=%0d col=%0d", $time,
                             o_cursor_row, o_cursor_col);
                    errors++;
                end else begin
                    want = pending_status.pop_front();
                    words_checked++;
                    if (o_cursor_row !== want.row) begin
                        $display("%0t: cursor_row expected %0d actual %0d", $time, want.row,
                                 o_cursor_row);
                        errors++;
                    end
                    if (o_cursor_col !== want.col) begin
                        $display("%0t: cursor_col expected %0d actual %0d", $time, want.col,
                                 o_cursor_col);
                        errors++;
                    end
                    if (o_attribute !== want.attr) begin
                        $display("%0t: attribute expected %h actual %h", $time, want.attr,
                                 o_attribute);
                        errors++;
                    end
                    if (o_hw_cursor_pos !== want.hw) begin
                        $display("%0t: hw_cursor_pos expected %0d actual %0d", $time, want.hw,
                                 o_hw_cursor_pos);
                        errors++;
                    end
                    if (o_cell_data !== want.cdata) begin
                        $display("%0t: cell_data expected %h actual %h", $time, want.cdata,
                                 o_cell_data);
                        errors++;
                    end
                end
            end
            // long hold-off on request, so the input queue backs up
            if (hold_req) begin
                hold_req = 1'b0;
                stall = 600;
            end
            if (stall > 0) begin
                stall--;
                i_pop <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) i_pop <= 1'b1;
                else begin
                    i_pop <= 1'b0;
                    stall = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 50);
                end
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_text_and_controls();
        send_word(1'b0, 8'hFF, 11'h7FF);
        send_word(1'b0, 8'h00, 11'h000);
        send_text("Hi");
        send_word(1'b0, 8'h0D, 11'($urandom));
        send_text("\n");
        // backspace from the start of a row wraps back to the end of the row above
        repeat (3) send_word(1'b0, 8'h08, 11'($urandom));
        read_cell(0);
        read_cell(NCELL - 1);
        read_cell(2047);           // beyond the screen reads zero
    endtask

    task automatic test_escapes();
        send_text({8'h1B, "x"});                     // dropped escape
        send_text({8'h1B, "[1;31;44m"});
        send_text({8'h1B, "[97;107m"});
        send_text({8'h1B, "[0m"});
        send_text({8'h1B, "[999;;;;;;;;;;1;2m"});    // wrapping digits and too many fields
        send_text({8'h1B, "[5;20H"});
        send_text({8'h1B, "[0A", 8'h1B, "[99B", 8'h1B, "[200C", 8'h1B, "[D"});
        send_text({8'h1B, "[s", 8'h1B, "[99;99f", 8'h1B, "[u"});
        send_text({8'h1B, "[0K", 8'h1B, "[1K", 8'h1B, "[2K", 8'h1B, "[5K"});
        send_text({8'h1B, "[1J", 8'h1B, "[z", 8'h1B, "[", 8'h1B});
        send_text({8'h1B, "[44m", 8'h1B, "[2J"});
        read_cell(5);
    endtask

    function automatic string random_escape();
        string s, finals;
        int np;
        finals = "mABCDHfJKsu";
        s = {8'h1B, "["};
        np = $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0) np = $urandom_range(4, 11);
        for (int i = 0; i < np; i++) begin
            if (i > 0) s = {s, ";"};
            if ($urandom_range(0, 3) != 0) s = {s, $sformatf("%0d", $urandom_range(0, 110))};
            else if ($urandom_range(0, 3) == 0) s = {s, $sformatf("%0d", $urandom_range(0, 9999))};
        end
        if ($urandom_range(0, 9) == 0) s = {s, 8'($urandom)};
        else begin
            s = {s, finals[$urandom_range(0, finals.len() - 1)]};
            // clear screen is slow, keep it rare
            if (s[s.len() - 1] == "J" && $urandom_range(0, 7) != 0) s[s.len() - 1] = "K";
        end
        return s;
    endfunction

    task automatic test_random_stream(input int target);
        int r;
        while (words_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 15) read_cell($urandom_range(0, 9) == 0 ? $urandom_range(0, 2047)
                                                            : $urandom_range(0, NCELL - 1));
            else if (r < 40) send_text(random_escape());
            else if (r < 43) send_text("\n");
            else if (r < 46) send_word(1'b0, ($urandom_range(0, 1) != 0) ? 8'h0D : 8'h08,
                                       11'($urandom));
            else if (r < 49) send_word(1'b0, 8'($urandom), 11'($urandom));
            else if (r < 51) send_text({8'h1B, 8'($urandom)});
            else send_word(1'b0, 8'($urandom_range(32, 126)), 11'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_word(1'b0, 8'($urandom_range(65, 90)), 11'($urandom));
    endtask

    initial begin : stimulus
        for (int x = 0; x < NCELL; x++) screen[x] = CELL_DEF;
        cur_row = 0; cur_col = 0; save_row = 0; save_col = 0;
        cur_attr = ATTR_DEF;
        pmode = PS_TEXT;
        for (int i = 0; i < NPAR; i++) pars[i] = 8'd0;
        par_cnt = 0;
        hw_pos = 11'd0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_text_and_controls();
        test_escapes();
        test_backpressure();
        test_random_stream(1800);

        i_push <= 1'b0;
        wait (pending_status.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("covered text, controls, escapes, reads and a filled input queue");
        $display("%0d words sent, %0d status words checked", words_sent, words_checked);
        if (errors == 0 && pending_status.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
